[hdl/lsor_pkg.sv]
package lsor_pkg;

    localparam int GRID_LOG2 = 6;
    localparam int GRID_SIZE = 1 << GRID_LOG2;
    localparam int ADDR_W    = 2 * GRID_LOG2;
    localparam int POT_W     = 24;
    localparam int OMEGA_W   = 15;
    localparam int COUNT_W   = 16;
    localparam int CFG_W     = 16;
    localparam int SUM_W     = POT_W + 3;
    localparam int PROD_W    = SUM_W + OMEGA_W + 1;
    localparam int FRAC_SH   = 16;

    localparam logic [GRID_LOG2-1:0] IDX_FIRST = GRID_LOG2'(1);
    localparam logic [GRID_LOG2-1:0] IDX_LAST  = GRID_LOG2'(GRID_SIZE - 2);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic CFG_OMEGA = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic [OMEGA_W-1:0] OMEGA_RESET = OMEGA_W'(31213);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1000);

    typedef enum logic [1:0] {
        WS_HOST  = 2'd0,
        WS_RELAX = 2'd1,
        WS_ZERO  = 2'd2
    } t_wsel;

    typedef enum logic [1:0] {
        CAP_NONE      = 2'd0,
        CAP_SELF_UP   = 2'd1,
        CAP_DOWN_LEFT = 2'd2
    } t_cap;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_wsel             wsel;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        t_cap              cap;
        logic              calc_d;
        logic              calc_p;
        logic              out_load;
        logic              out_read;
    } t_cmd;

    typedef struct packed {
        logic self_fixed;
    } t_status;

endpackage

[hdl/lsor_in_if.sv]
interface lsor_in_if
    import lsor_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic [GRID_LOG2-1:0]    row;
    logic [GRID_LOG2-1:0]    col;
    logic signed [POT_W-1:0] potential;
    logic                    fixed;

    modport source (output valid, opcode, row, col, potential, fixed, input ready);
    modport sink   (input valid, opcode, row, col, potential, fixed, output ready);
endinterface

[hdl/lsor_out_if.sv]
interface lsor_out_if
    import lsor_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POT_W-1:0] cell_value;
    logic                    cell_fixed;

    modport source (output valid, cell_value, cell_fixed, input ready);
    modport sink   (input valid, cell_value, cell_fixed, output ready);
endinterface

[hdl/lsor_dp.sv]
module lsor_dp
    import lsor_pkg::*;
(
    input  logic                    i_clk,
    input  t_cmd                    i_cmd,
    input  logic [OMEGA_W-1:0]      i_omega,
    input  logic signed [POT_W-1:0] i_potential,
    input  logic                    i_fixed,
    output t_status                 o_status,
    output logic signed [POT_W-1:0] o_cell_value,
    output logic                    o_cell_fixed
);

    logic [POT_W:0] mem [GRID_SIZE*GRID_SIZE];
    logic [POT_W:0] r_qa;
    logic [POT_W:0] r_qb;

    logic signed [POT_W-1:0]  r_v;
    logic signed [POT_W-1:0]  r_up;
    logic signed [POT_W-1:0]  r_dn;
    logic signed [POT_W-1:0]  r_lf;
    logic                     r_self_fixed;
    logic signed [SUM_W-1:0]  r_d;
    logic signed [PROD_W-1:0] r_p;
    logic signed [POT_W-1:0]  r_out_value;
    logic                     r_out_fixed;

    logic signed [SUM_W-1:0]  n_d;
    logic signed [PROD_W-1:0] n_p;
    logic signed [PROD_W-1:0] p_rnd;
    logic signed [SUM_W-1:0]  step;
    logic signed [SUM_W:0]    n_sum;
    logic signed [POT_W-1:0]  relaxed;
    logic [POT_W:0]           wdata;

    always_comb begin
        n_d = SUM_W'(r_up) + SUM_W'(r_dn) + SUM_W'(r_lf)
            + SUM_W'($signed(r_qa[POT_W-1:0])) - (SUM_W'(r_v) <<< 2);
        n_p = $signed({1'b0, i_omega}) * r_d;
        // round half up, then floor shift
        p_rnd = r_p + PROD_W'(32768);
        step  = p_rnd[PROD_W-1:FRAC_SH];
        n_sum = (SUM_W+1)'(r_v) + (SUM_W+1)'(step);
        if (n_sum > (SUM_W+1)'(2**(POT_W-1) - 1)) begin
            relaxed = {1'b0, {(POT_W-1){1'b1}}};
        end else if (n_sum < -(SUM_W+1)'(2**(POT_W-1))) begin
            relaxed = {1'b1, {(POT_W-1){1'b0}}};
        end else begin
            relaxed = n_sum[POT_W-1:0];
        end
        unique case (i_cmd.wsel)
            WS_HOST:  wdata = {i_fixed, i_potential};
            WS_RELAX: wdata = {1'b0, relaxed};
            WS_ZERO:  wdata = '0;
            default:  wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.waddr] <= wdata;
        end
        r_qa <= mem[i_cmd.raddr_a];
        r_qb <= mem[i_cmd.raddr_b];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.cap)
            CAP_SELF_UP: begin
                r_v          <= r_qa[POT_W-1:0];
                r_self_fixed <= r_qa[POT_W];
                r_up         <= r_qb[POT_W-1:0];
            end
            CAP_DOWN_LEFT: begin
                r_dn <= r_qa[POT_W-1:0];
                r_lf <= r_qb[POT_W-1:0];
            end
            CAP_NONE: begin
            end
            default: begin
            end
        endcase
        if (i_cmd.calc_d) begin
            r_d <= n_d;
        end
        if (i_cmd.calc_p) begin
            r_p <= n_p;
        end
        if (i_cmd.out_load) begin
            r_out_value <= i_cmd.out_read ? r_qa[POT_W-1:0] : '0;
            r_out_fixed <= i_cmd.out_read ? r_qa[POT_W] : 1'b0;
        end
    end

    assign o_status.self_fixed = r_self_fixed;
    assign o_cell_value        = r_out_value;
    assign o_cell_fixed        = r_out_fixed;

endmodule

[hdl/lsor_ctrl.sv]
module lsor_ctrl
    import lsor_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_opcode,
    input  logic [GRID_LOG2-1:0] i_row,
    input  logic [GRID_LOG2-1:0] i_col,
    input  logic                 i_out_ready,
    input  logic [COUNT_W-1:0]   i_sweep_count,
    input  t_status              i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output t_cmd                 o_cmd
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RDOUT = 11'b00000000100,
        S_START = 11'b00000001000,
        S_RD0   = 11'b00000010000,
        S_RD1   = 11'b00000100000,
        S_RD2   = 11'b00001000000,
        S_SUM   = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_WR    = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr, n_clr;
    logic [GRID_LOG2-1:0] r_row, n_row;
    logic [GRID_LOG2-1:0] r_col, n_col;
    logic [COUNT_W-1:0]   r_sweep, n_sweep;
    logic                 r_out_valid, n_out_valid;
    logic                 accept;
    logic                 last_sweep;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;
    assign last_sweep  = (r_sweep + COUNT_W'(1)) == i_sweep_count;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_row       = r_row;
        n_col       = r_col;
        n_sweep     = r_sweep;
        n_out_valid = r_out_valid && !i_out_ready;

        o_cmd          = '0;
        o_cmd.wsel     = WS_ZERO;
        o_cmd.cap      = CAP_NONE;
        o_cmd.raddr_a  = {r_row, r_col};
        o_cmd.raddr_b  = {r_row - GRID_LOG2'(1), r_col};
        o_cmd.waddr    = {r_row, r_col};

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = r_clr;
                n_clr       = r_clr + ADDR_W'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.raddr_a = {i_row, i_col};
                o_cmd.waddr   = {i_row, i_col};
                o_cmd.wsel    = WS_HOST;
                if (accept) begin
                    unique case (i_opcode)
                        OP_WRITE: begin
                            o_cmd.we       = 1'b1;
                            o_cmd.out_load = 1'b1;
                            n_out_valid    = 1'b1;
                        end
                        OP_RUN: begin
                            n_out_valid = 1'b0;
                            n_state     = S_START;
                        end
                        OP_READ: begin
                            n_out_valid = 1'b0;
                            n_state     = S_RDOUT;
                        end
                        OP_NOP: begin
                            o_cmd.out_load = 1'b1;
                            n_out_valid    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDOUT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_read = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            S_START: begin
                n_sweep = '0;
                n_row   = IDX_FIRST;
                n_col   = IDX_FIRST;
                n_state = (i_sweep_count == '0) ? S_DONE : S_RD0;
            end
            S_RD0: begin
                n_state = S_RD1;
            end
            S_RD1: begin
                o_cmd.cap     = CAP_SELF_UP;
                o_cmd.raddr_a = {r_row + GRID_LOG2'(1), r_col};
                o_cmd.raddr_b = {r_row, r_col - GRID_LOG2'(1)};
                n_state       = S_RD2;
            end
            S_RD2: begin
                o_cmd.cap     = CAP_DOWN_LEFT;
                o_cmd.raddr_a = {r_row, r_col + GRID_LOG2'(1)};
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.calc_d = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.calc_p = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_RELAX;
            end
            S_DONE: begin
                o_cmd.out_load = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance to the next interior cell; skip held cells
        if ((r_state == S_WR) || ((r_state == S_SUM) && i_status.self_fixed)) begin
            n_state = S_RD0;
            if (r_col == IDX_LAST) begin
                n_col = IDX_FIRST;
                if (r_row == IDX_LAST) begin
                    n_row   = IDX_FIRST;
                    n_sweep = r_sweep + COUNT_W'(1);
                    if (last_sweep) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_row = r_row + GRID_LOG2'(1);
                end
            end else begin
                n_col = r_col + GRID_LOG2'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_row       <= IDX_FIRST;
            r_col       <= IDX_FIRST;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hdl/laplace_sor_grid_solver_core.sv]
// Channel  Dir  Beat contents
// i_in     in   opcode, row, col, potential, fixed
// o_out    out  cell_value, cell_fixed
// i_cfg_*  in   write enable, register index, data (no handshake)
//
// Write and no-op beats are answered in the next cycle; a read passes through
// S_RDOUT for its registered memory read. A run makes sweep_count sweeps:
// each interior cell uses three read states on the two-port grid memory, a sum,
// a multiply and a write-back; held cells leave after the sum.
// After reset a clearing pass writes zero to all 4096 cells, one per cycle,
// before the first command beat is taken. A stalled result beat holds the block.
module laplace_sor_grid_solver_core
    import lsor_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    lsor_in_if.sink          i_in,
    lsor_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [OMEGA_W-1:0] r_omega, n_omega;
    logic [COUNT_W-1:0] r_count, n_count;
    t_cmd               cmd;
    t_status            status;

    always_comb begin
        n_omega = r_omega;
        n_count = r_count;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OMEGA: n_omega = i_cfg_data[OMEGA_W-1:0];
                CFG_COUNT: n_count = i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega <= OMEGA_RESET;
            r_count <= COUNT_RESET;
        end else begin
            r_omega <= n_omega;
            r_count <= n_count;
        end
    end

    lsor_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_opcode      (i_in.opcode),
        .i_row         (i_in.row),
        .i_col         (i_in.col),
        .i_out_ready   (o_out.ready),
        .i_sweep_count (r_count),
        .i_status      (status),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .o_cmd         (cmd)
    );

    lsor_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_omega      (r_omega),
        .i_potential  (i_in.potential),
        .i_fixed      (i_in.fixed),
        .o_status     (status),
        .o_cell_value (o_out.cell_value),
        .o_cell_fixed (o_out.cell_fixed)
    );

`ifndef ASSERT_OFF
    a_write_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.opcode == OP_WRITE || i_in.opcode == OP_NOP))
        |=> (o_out.valid && o_out.cell_value == '0 && !o_out.cell_fixed))
        else $error("write or no-op beat gave no zero result");
    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.opcode == OP_READ) |=> ##1 o_out.valid)
        else $error("read beat gave no result after two cycles");
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.opcode == OP_RUN) |=> (!o_out.valid && !i_in.ready))
        else $error("run beat did not hold the block");
`endif

endmodule
